>>> rtl/asw_pkg.sv
// Package for the adaptive support weight block: widths, the exp root table
// and the radius table. Used by asw_exp and adaptive_support_weight.
package asw_pkg;

  localparam int MaxRadius = 16;
  localparam int RadW = 5;
  localparam int NumPairs = (MaxRadius + 1) * (MaxRadius + 2) / 2;
  localparam int PairW = $clog2(NumPairs);
  localparam int SqW = 22;
  localparam int TW = 27;
  localparam int WW = 17;
  localparam int ExpLat = 18;
  localparam logic [16:0] Log2eQ16 = 17'd94548;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_COLOR = 2'd1,
    REG_DIST  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_FIRST = 3'd0,
    MODE_LEFT  = 3'd1,
    MODE_MAX   = 3'd2,
    MODE_MIN   = 3'd3,
    MODE_PROD  = 3'd4,
    MODE_SUM   = 3'd5
  } mode_t;

  typedef logic [29:0] root_arr_t [17];
  typedef logic [SqW-1:0] sq_arr_t [NumPairs];
  typedef logic [PairW-1:0] tri_arr_t [MaxRadius + 1];

  function automatic logic [63:0] isqrt64(input logic [63:0] xin);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bitv;
    x = xin;
    res = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 64'd0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic root_arr_t make_roots();
    root_arr_t r;
    logic [63:0] c;
    c = 64'd1 << 29;
    r[0] = 30'(c);
    for (int i = 1; i <= 16; i++) begin
      c = isqrt64(c << 30);
      r[i] = 30'(c);
    end
    return r;
  endfunction

  function automatic tri_arr_t make_tri();
    tri_arr_t t;
    for (int a = 0; a <= MaxRadius; a++) t[a] = PairW'(a * (a + 1) / 2);
    return t;
  endfunction

  function automatic sq_arr_t make_sq();
    sq_arr_t s;
    logic [63:0] r2;
    for (int a = 0; a <= MaxRadius; a++) begin
      for (int b = 0; b <= a; b++) begin
        r2 = 64'(a * a + b * b);
        s[a * (a + 1) / 2 + b] = SqW'(isqrt64(r2 << 32));
      end
    end
    return s;
  endfunction

  localparam root_arr_t Roots = make_roots();
  localparam tri_arr_t TriBase = make_tri();
  localparam sq_arr_t SqTable = make_sq();

endpackage

>>> rtl/asw_exp.sv
// Pipelined exp(-t) in Q1.16: one stage scales by log2(e), sixteen stages
// apply one fraction bit each, a last stage shifts and rounds. Uses asw_pkg.
module asw_exp (
  input  logic                      clk,
  input  logic [asw_pkg::TW-1:0]    t,
  output logic [asw_pkg::WW-1:0]    w
);

  logic [30:0] p [17];
  logic [15:0] fr [17];
  logic [4:0]  nn [17];
  logic        big [17];
  logic [43:0] u;

  assign u = 44'(t) * 44'(asw_pkg::Log2eQ16);

  always_ff @(posedge clk) begin
    p[0]   <= 31'd1 << 30;
    fr[0]  <= u[31:16];
    nn[0]  <= u[36:32];
    big[0] <= (u[43:32] >= 12'd31);
  end

  for (genvar i = 1; i <= 16; i++) begin : g_step
    logic [61:0] prod;
    assign prod = 62'(p[i-1]) * 62'(asw_pkg::Roots[i]) + (62'd1 << 29);
    always_ff @(posedge clk) begin
      if (fr[i-1][16-i]) begin
        p[i] <= 31'(prod >> 30);
      end else begin
        p[i] <= p[i-1];
      end
      fr[i]  <= fr[i-1];
      nn[i]  <= nn[i-1];
      big[i] <= big[i-1];
    end
  end

  logic [5:0]  sh;
  logic [47:0] rounded;

  assign sh = 6'd14 + 6'(nn[16]);
  assign rounded = (48'(p[16]) + (48'd1 << (sh - 6'd1))) >> sh;

  always_ff @(posedge clk) begin
    if (big[16]) begin
      w <= '0;
    end else begin
      w <= asw_pkg::WW'(rounded);
    end
  end

endmodule

>>> rtl/adaptive_support_weight.sv
// Top level of the adaptive support weight block: input stages, three exp
// pipelines (asw_exp), combine and rescale stages. Uses asw_pkg.
//
// A neighbor item is taken in every cycle that start is high; busy is always
// low. Its weight_level appears with done, for one cycle, and results come
// out in the order items went in. The depth is set by the exp pipelines,
// which spend one multiply stage on each of sixteen fraction bits.
// Configuration writes are always ready and should be made with no items in
// flight.
module adaptive_support_weight (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] center_first_rgb,
  input  logic [23:0] neighbor_first_rgb,
  input  logic [23:0] center_second_rgb,
  input  logic [23:0] neighbor_second_rgb,
  input  logic signed [5:0] offset_x,
  input  logic signed [5:0] offset_y,
  input  logic        inside_first,
  input  logic        inside_second,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [7:0]  weight_level
);

  localparam int Lat = 6 + asw_pkg::ExpLat;

  logic [2:0]  combine_mode;
  logic [15:0] color_scale;
  logic [15:0] distance_scale;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      combine_mode   <= 3'd0;
      color_scale    <= 16'd1820;
      distance_scale <= 16'd3745;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        asw_pkg::REG_MODE:  combine_mode   <= cfg_data[2:0];
        asw_pkg::REG_COLOR: color_scale    <= cfg_data;
        asw_pkg::REG_DIST:  distance_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  logic comb;
  assign comb = (combine_mode >= asw_pkg::MODE_LEFT) && (combine_mode <= asw_pkg::MODE_SUM);

  function automatic logic [9:0] l1(input logic [23:0] a, input logic [23:0] b);
    logic [9:0] s;
    s = '0;
    for (int k = 0; k < 3; k++) begin
      if (a[8*k +: 8] > b[8*k +: 8]) s = s + 10'(a[8*k +: 8] - b[8*k +: 8]);
      else s = s + 10'(b[8*k +: 8] - a[8*k +: 8]);
    end
    return s;
  endfunction

  logic [5:0] adx;
  logic [5:0] ady;
  logic       excl_in;
  assign adx = offset_x[5] ? 6'(-offset_x) : offset_x;
  assign ady = offset_y[5] ? 6'(-offset_y) : offset_y;
  assign excl_in = !inside_first || (comb && !inside_second) ||
                   (adx > 6'(asw_pkg::MaxRadius)) || (ady > 6'(asw_pkg::MaxRadius));

  logic [Lat-1:0] vpipe;
  logic [Lat-1:0] xpipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[Lat-2:0], start};
    end
    xpipe <= {xpipe[Lat-2:0], excl_in};
  end

  // Stage 1: L1 distances and sorted offsets.
  logic [9:0] d1;
  logic [9:0] d2;
  logic [asw_pkg::RadW-1:0] ra;
  logic [asw_pkg::RadW-1:0] rb;

  always_ff @(posedge clk) begin
    d1 <= l1(center_first_rgb, neighbor_first_rgb);
    d2 <= l1(center_second_rgb, neighbor_second_rgb);
    if (adx >= ady) begin
      ra <= asw_pkg::RadW'(adx);
      rb <= asw_pkg::RadW'(ady);
    end else begin
      ra <= asw_pkg::RadW'(ady);
      rb <= asw_pkg::RadW'(adx);
    end
  end

  // Stage 2: color exponents and radius lookup.
  logic [25:0] tc1;
  logic [25:0] tc2;
  logic [asw_pkg::SqW-1:0] sq;
  logic [asw_pkg::RadW-1:0] ra_c;
  logic [asw_pkg::RadW-1:0] rb_c;
  logic [asw_pkg::PairW-1:0] pidx;

  assign ra_c = (ra > asw_pkg::RadW'(asw_pkg::MaxRadius)) ?
                asw_pkg::RadW'(asw_pkg::MaxRadius) : ra;
  assign rb_c = (rb > ra_c) ? ra_c : rb;
  assign pidx = asw_pkg::TriBase[ra_c] + asw_pkg::PairW'(rb_c);

  always_ff @(posedge clk) begin
    tc1 <= 26'(d1) * 26'(color_scale);
    tc2 <= 26'(d2) * 26'(color_scale);
    sq  <= asw_pkg::SqTable[pidx];
  end

  // Stage 3: spatial exponent.
  logic [25:0] tc1_r;
  logic [25:0] tc2_r;
  logic [asw_pkg::TW-1:0] ts;
  logic [38:0] sprod;

  assign sprod = (39'(sq) * 39'(distance_scale)) << comb;

  always_ff @(posedge clk) begin
    tc1_r <= tc1;
    tc2_r <= tc2;
    ts    <= asw_pkg::TW'(sprod >> 16);
  end

  logic [asw_pkg::WW-1:0] w1;
  logic [asw_pkg::WW-1:0] w2;
  logic [asw_pkg::WW-1:0] sp;

  asw_exp u_exp_first  (.clk(clk), .t(asw_pkg::TW'(tc1_r)), .w(w1));
  asw_exp u_exp_second (.clk(clk), .t(asw_pkg::TW'(tc2_r)), .w(w2));
  asw_exp u_exp_space  (.clk(clk), .t(ts),                  .w(sp));

  // Combine stage.
  logic [17:0] wc;
  logic [17:0] wc_next;
  logic [16:0] sp_r;
  logic [33:0] pw;

  assign pw = (34'(w1) * 34'(w2) + 34'd32768) >> 16;

  always_comb begin
    case (combine_mode)
      asw_pkg::MODE_MAX:  wc_next = (w1 > w2) ? 18'(w1) : 18'(w2);
      asw_pkg::MODE_MIN:  wc_next = (w1 < w2) ? 18'(w1) : 18'(w2);
      asw_pkg::MODE_PROD: wc_next = 18'(pw);
      asw_pkg::MODE_SUM:  wc_next = 18'(w1) + 18'(w2);
      default:            wc_next = 18'(w1);
    endcase
  end

  always_ff @(posedge clk) begin
    wc   <= wc_next;
    sp_r <= sp;
  end

  // Total weight stage.
  logic [18:0] wt;
  logic [35:0] wprod;
  assign wprod = (36'(wc) * 36'(sp_r) + 36'd32768) >> 16;

  always_ff @(posedge clk) begin
    wt <= 19'(wprod);
  end

  // Rescale stage.
  logic [27:0] scaled;
  logic [27:0] lvl;
  assign scaled = 28'(wt) * 28'd255;
  assign lvl = (combine_mode == asw_pkg::MODE_SUM) ? ((scaled + 28'd65536) >> 17) :
                                                     ((scaled + 28'd32768) >> 16);

  always_ff @(posedge clk) begin
    if (xpipe[Lat-2]) begin
      weight_level <= 8'd0;
    end else if (lvl > 28'd255) begin
      weight_level <= 8'd255;
    end else begin
      weight_level <= lvl[7:0];
    end
  end

  assign done = vpipe[Lat-1];

endmodule
